### rtl/rsfl_pkg.sv
// shared types and constants of the record slot free list
package rsfl_pkg;

   localparam int SLOT_COUNT  = 256;
   localparam int STORE_BYTES = 1048576;
   localparam int MAX_RECORD  = 4095;

   localparam int SLOT_W    = $clog2(SLOT_COUNT);
   localparam int LINK_W    = SLOT_W + 1;
   localparam int OFFSET_W  = 20;
   localparam int LENGTH_W  = 12;
   localparam int LEN_SUM_W = LENGTH_W + 1;
   localparam int STORE_W   = OFFSET_W + 1;
   localparam int SUM_W     = STORE_W + 1;
   localparam int FUNC_W    = 2;
   localparam int STATUS_W  = 3;

   localparam logic [LINK_W-1:0]    LINK_NONE   = LINK_W'(SLOT_COUNT);
   localparam logic [SUM_W-1:0]     STORE_LIMIT = SUM_W'(STORE_BYTES);
   localparam logic [LEN_SUM_W-1:0] LEN_LIMIT   = LEN_SUM_W'(MAX_RECORD);

   localparam logic [FUNC_W-1:0] FN_ALLOC  = 2'd0;
   localparam logic [FUNC_W-1:0] FN_FREE   = 2'd1;
   localparam logic [FUNC_W-1:0] FN_LOOKUP = 2'd2;

   typedef enum logic [1:0] {
      OP_ALLOC,
      OP_FREE,
      OP_LOOKUP,
      OP_NONE
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK,
      ST_RANGE,
      ST_DELETED,
      ST_TABLE_FULL,
      ST_STORE_FULL
   } status_type;

   typedef enum logic {
      BK_IDLE,
      BK_READ
   } back_state_type;

   typedef struct packed {
      op_type              op;
      logic                too_long;
      logic [LENGTH_W-1:0] length;
      logic [SLOT_W-1:0]   index;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } cmd_head_type;

   typedef struct packed {
      logic [OFFSET_W-1:0] offset;
      logic [LENGTH_W-1:0] length;
      logic                valid;
      logic [LINK_W-1:0]   link;
   } slot_entry_type;

endpackage

### rtl/record_slot_free_list_core.sv
// top level of the record slot free list allocator
//
// Request channel (req_): func selects allocate, free or look up; allocate
// uses record_length, free and look up use slot_index. A transfer happens
// when req_valid is high and req_stall is low. Requests enter a two entry
// queue; req_stall is high only while that queue is full.
// Response channel (rsp_): one response per request, in request order, held
// in an output register until a transfer with rsp_stall low.
// Requests settled without a slot table read (range errors, table or store
// full, appends, unused func codes) pass the queue and the output register;
// reuse, free and look up also pass the registered slot table read. Requests
// without a read go at one request per cycle while the output is not stalled;
// a table read holds the next request back, as the single slot table memory
// has a registered read and the free-list head is only known after that read.
// While the receiver stalls, the queue still takes up to two requests.
// Reset empties the queue and the free list and clears the slot and store
// counts; slot table contents are left as they are and need no clearing.
module record_slot_free_list_core
   import rsfl_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [FUNC_W-1:0]   req_func,
   input  logic [LENGTH_W-1:0] req_record_length,
   input  logic [SLOT_W-1:0]   req_slot_index,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [SLOT_W-1:0]   rsp_result_index,
   output logic [OFFSET_W-1:0] rsp_result_offset,
   output logic [LENGTH_W-1:0] rsp_result_length,
   output logic                rsp_reused
);

   logic         push;
   cmd_type      push_cmd;
   logic         full;
   logic         pop;
   cmd_head_type head;

   rsfl_front u_front (
      .req_valid         (req_valid),
      .req_func          (req_func),
      .req_record_length (req_record_length),
      .req_slot_index    (req_slot_index),
      .push              (push),
      .cmd               (push_cmd)
   );

   rsfl_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .full     (full),
      .pop      (pop),
      .head     (head)
   );

   rsfl_back u_back (
      .clock             (clock),
      .reset             (reset),
      .head              (head),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_result_index  (rsp_result_index),
      .rsp_result_offset (rsp_result_offset),
      .rsp_result_length (rsp_result_length),
      .rsp_reused        (rsp_reused)
   );

   assign req_stall = full;

endmodule

### rtl/rsfl_ram.sv
// generic single write port ram with registered read
module rsfl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/rsfl_front.sv
// request classification: decodes the function and forms the stored length
module rsfl_front
   import rsfl_pkg::*;
(
   input  logic                req_valid,
   input  logic [FUNC_W-1:0]   req_func,
   input  logic [LENGTH_W-1:0] req_record_length,
   input  logic [SLOT_W-1:0]   req_slot_index,
   output logic                push,
   output cmd_type             cmd
);

   logic [LEN_SUM_W-1:0] len_sum;

   always_comb begin
      len_sum      = LEN_SUM_W'(req_record_length) + LEN_SUM_W'(1);
      cmd.too_long = len_sum > LEN_LIMIT;
      cmd.length   = len_sum[LENGTH_W-1:0];
      cmd.index    = req_slot_index;
      case (req_func)
         FN_ALLOC:  cmd.op = OP_ALLOC;
         FN_FREE:   cmd.op = OP_FREE;
         FN_LOOKUP: cmd.op = OP_LOOKUP;
         default:   cmd.op = OP_NONE;
      endcase
      push = req_valid;
   end

endmodule

### rtl/rsfl_queue.sv
// two entry command queue between front and back
module rsfl_queue
   import rsfl_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  cmd_type      push_cmd,
   output logic         full,
   input  logic         pop,
   output cmd_head_type head
);

   cmd_type    entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   always_comb begin
      full       = count_ff == 2'd2;
      do_push    = push && !full;
      do_pop     = pop && (count_ff != 2'd0);
      wr_ptr_in  = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in  = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in   = count_ff + {1'b0, do_push} - {1'b0, do_pop};
      head.valid = count_ff != 2'd0;
      head.cmd   = entry_ff[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

### rtl/rsfl_back.sv
// command execution: slot table access, free list and store end tracking
module rsfl_back
   import rsfl_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  cmd_head_type        head,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [SLOT_W-1:0]   rsp_result_index,
   output logic [OFFSET_W-1:0] rsp_result_offset,
   output logic [LENGTH_W-1:0] rsp_result_length,
   output logic                rsp_reused
);

   back_state_type      state_ff, state_in;
   logic [LINK_W-1:0]   free_head_ff, free_head_in;
   logic [LINK_W-1:0]   slots_used_ff, slots_used_in;
   logic [STORE_W-1:0]  store_end_ff, store_end_in;
   cmd_type             cur_ff, cur_in;

   logic                rsp_valid_ff, rsp_valid_in;
   status_type          status_ff, status_in;
   logic [SLOT_W-1:0]   index_ff, index_in;
   logic [OFFSET_W-1:0] offset_ff, offset_in;
   logic [LENGTH_W-1:0] length_ff, length_in;
   logic                reused_ff, reused_in;

   logic                rd_en, wr_en;
   logic [SLOT_W-1:0]   rd_addr, wr_addr;
   slot_entry_type      wr_data, rd_data;
   logic [$bits(slot_entry_type)-1:0] rd_bits;

   logic                out_free;
   logic [SUM_W-1:0]    append_sum, reuse_sum;

   rsfl_ram #(
      .WIDTH($bits(slot_entry_type)),
      .DEPTH(SLOT_COUNT)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_bits)
   );

   assign rd_data = slot_entry_type'(rd_bits);

   always_comb begin
      state_in      = state_ff;
      free_head_in  = free_head_ff;
      slots_used_in = slots_used_ff;
      store_end_in  = store_end_ff;
      cur_in        = cur_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      status_in     = status_ff;
      index_in      = index_ff;
      offset_in     = offset_ff;
      length_in     = length_ff;
      reused_in     = reused_ff;
      pop           = 1'b0;
      rd_en         = 1'b0;
      rd_addr       = '0;
      wr_en         = 1'b0;
      wr_addr       = '0;
      wr_data       = '0;
      out_free      = !rsp_valid_ff || !rsp_stall;
      append_sum    = SUM_W'(store_end_ff) + SUM_W'(head.cmd.length);
      reuse_sum     = SUM_W'(rd_data.offset) + SUM_W'(cur_ff.length);

      case (state_ff)
         BK_IDLE: begin
            if (head.valid && out_free) begin
               pop       = 1'b1;
               cur_in    = head.cmd;
               index_in  = '0;
               offset_in = '0;
               length_in = '0;
               reused_in = 1'b0;
               case (head.cmd.op)
                  OP_ALLOC: begin
                     if (head.cmd.too_long) begin
                        rsp_valid_in = 1'b1;
                        status_in    = ST_STORE_FULL;
                     end else if (free_head_ff != LINK_NONE) begin
                        rd_en    = 1'b1;
                        rd_addr  = free_head_ff[SLOT_W-1:0];
                        state_in = BK_READ;
                     end else if (slots_used_ff == LINK_NONE) begin
                        rsp_valid_in = 1'b1;
                        status_in    = ST_TABLE_FULL;
                     end else if (append_sum > STORE_LIMIT) begin
                        rsp_valid_in = 1'b1;
                        status_in    = ST_STORE_FULL;
                     end else begin
                        wr_en          = 1'b1;
                        wr_addr        = slots_used_ff[SLOT_W-1:0];
                        wr_data.offset = store_end_ff[OFFSET_W-1:0];
                        wr_data.length = head.cmd.length;
                        wr_data.valid  = 1'b1;
                        wr_data.link   = LINK_NONE;
                        slots_used_in  = slots_used_ff + LINK_W'(1);
                        store_end_in   = append_sum[STORE_W-1:0];
                        rsp_valid_in   = 1'b1;
                        status_in      = ST_OK;
                        index_in       = slots_used_ff[SLOT_W-1:0];
                        offset_in      = store_end_ff[OFFSET_W-1:0];
                        length_in      = head.cmd.length;
                     end
                  end
                  OP_FREE, OP_LOOKUP: begin
                     if ({1'b0, head.cmd.index} >= slots_used_ff) begin
                        rsp_valid_in = 1'b1;
                        status_in    = ST_RANGE;
                        index_in     = head.cmd.index;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = head.cmd.index;
                        state_in = BK_READ;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                     status_in    = ST_OK;
                  end
               endcase
            end
         end
         BK_READ: begin
            state_in     = BK_IDLE;
            rsp_valid_in = 1'b1;
            case (cur_ff.op)
               OP_ALLOC: begin
                  if (reuse_sum > STORE_LIMIT) begin
                     status_in = ST_STORE_FULL;
                  end else begin
                     wr_en          = 1'b1;
                     wr_addr        = free_head_ff[SLOT_W-1:0];
                     wr_data.offset = rd_data.offset;
                     wr_data.length = cur_ff.length;
                     wr_data.valid  = 1'b1;
                     wr_data.link   = LINK_NONE;
                     free_head_in   = rd_data.link;
                     if (reuse_sum > SUM_W'(store_end_ff)) begin
                        store_end_in = reuse_sum[STORE_W-1:0];
                     end
                     status_in = ST_OK;
                     index_in  = free_head_ff[SLOT_W-1:0];
                     offset_in = rd_data.offset;
                     length_in = cur_ff.length;
                     reused_in = 1'b1;
                  end
               end
               default: begin
                  index_in = cur_ff.index;
                  if (!rd_data.valid) begin
                     status_in = ST_DELETED;
                  end else begin
                     if (cur_ff.op == OP_FREE) begin
                        wr_en          = 1'b1;
                        wr_addr        = cur_ff.index;
                        wr_data.offset = rd_data.offset;
                        wr_data.length = rd_data.length;
                        wr_data.valid  = 1'b0;
                        wr_data.link   = free_head_ff;
                        free_head_in   = {1'b0, cur_ff.index};
                     end
                     status_in = ST_OK;
                     offset_in = rd_data.offset;
                     length_in = rd_data.length;
                  end
               end
            endcase
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= BK_IDLE;
         free_head_ff  <= LINK_NONE;
         slots_used_ff <= '0;
         store_end_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         free_head_ff  <= free_head_in;
         slots_used_ff <= slots_used_in;
         store_end_ff  <= store_end_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff    <= cur_in;
      status_ff <= status_in;
      index_ff  <= index_in;
      offset_ff <= offset_in;
      length_ff <= length_in;
      reused_ff <= reused_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = status_ff;
   assign rsp_result_index  = index_ff;
   assign rsp_result_offset = offset_ff;
   assign rsp_result_length = length_ff;
   assign rsp_reused        = reused_ff;

endmodule

### verif/record_slot_free_list_core_tb.sv
// testbench of the record slot free list core against a slot table predictor
module record_slot_free_list_core_tb;
   import rsfl_pkg::*;

   localparam logic [FUNC_W-1:0] FN_UNUSED = 2'd3;

   typedef struct {
      logic [FUNC_W-1:0]   func;
      logic [LENGTH_W-1:0] record_length;
      logic [SLOT_W-1:0]   slot_index;
   } request_type;

   typedef struct {
      status_type          status;
      logic [SLOT_W-1:0]   index;
      logic [OFFSET_W-1:0] offset;
      logic [LENGTH_W-1:0] length;
      logic                reused;
   } response_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [FUNC_W-1:0]   req_func = '0;
   logic [LENGTH_W-1:0] req_record_length = '0;
   logic [SLOT_W-1:0]   req_slot_index = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [STATUS_W-1:0] rsp_status;
   logic [SLOT_W-1:0]   rsp_result_index;
   logic [OFFSET_W-1:0] rsp_result_offset;
   logic [LENGTH_W-1:0] rsp_result_length;
   logic                rsp_reused;

   record_slot_free_list_core uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_func          (req_func),
      .req_record_length (req_record_length),
      .req_slot_index    (req_slot_index),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_result_index  (rsp_result_index),
      .rsp_result_offset (rsp_result_offset),
      .rsp_result_length (rsp_result_length),
      .rsp_reused        (rsp_reused)
   );

   always #10 clock = ~clock;

   // predicted slot table
   logic [STORE_W-1:0]  slot_start [SLOT_COUNT];
   logic [LENGTH_W-1:0] slot_size [SLOT_COUNT];
   logic                slot_live [SLOT_COUNT];
   logic [LINK_W-1:0]   slot_next [SLOT_COUNT];
   logic [LINK_W-1:0]   free_top = LINK_NONE;
   logic [LINK_W-1:0]   slots_taken = '0;
   logic [STORE_W-1:0]  store_top = '0;

   request_type    pending_requests[$];
   response_type   responses_due[$];
   int             error_count = 0;
   int             allocs_issued = 0;
   int             calm_tx = 0;
   int             calm_rx = 0;
   int             tx_gap = 0;
   int             rx_gap = 0;
   int             hold_left = 0;
   int             hold_asked = 0;
   int             hold_done = 0;

   initial begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
         slot_start[i] = '0;
         slot_size[i]  = '0;
         slot_live[i]  = 1'b0;
         slot_next[i]  = '0;
      end
   end

   function automatic response_type slot_table_update(input logic [FUNC_W-1:0] fn,
                                                      input logic [LENGTH_W-1:0] rec_len,
                                                      input logic [SLOT_W-1:0] idx);
      response_type         r;
      logic [LEN_SUM_W-1:0] need;
      logic [SUM_W-1:0]     stop;
      logic [SLOT_W-1:0]    pos;
      r.status = ST_OK;
      r.index  = '0;
      r.offset = '0;
      r.length = '0;
      r.reused = 1'b0;
      need = LEN_SUM_W'(rec_len) + 1'b1;
      case (fn)
         FN_ALLOC: begin
            if (need > LEN_LIMIT) begin
               r.status = ST_STORE_FULL;
            end else if (free_top != LINK_NONE) begin
               pos  = free_top[SLOT_W-1:0];
               stop = SUM_W'(slot_start[pos]) + SUM_W'(need);
               if (stop > STORE_LIMIT) begin
                  r.status = ST_STORE_FULL;
               end else begin
                  free_top       = slot_next[pos];
                  slot_size[pos] = need[LENGTH_W-1:0];
                  slot_live[pos] = 1'b1;
                  slot_next[pos] = LINK_NONE;
                  if (stop > SUM_W'(store_top)) store_top = stop[STORE_W-1:0];
                  r.index  = pos;
                  r.offset = slot_start[pos][OFFSET_W-1:0];
                  r.length = need[LENGTH_W-1:0];
                  r.reused = 1'b1;
               end
            end else if (slots_taken >= LINK_W'(SLOT_COUNT)) begin
               r.status = ST_TABLE_FULL;
            end else begin
               stop = SUM_W'(store_top) + SUM_W'(need);
               if (stop > STORE_LIMIT) begin
                  r.status = ST_STORE_FULL;
               end else begin
                  pos             = slots_taken[SLOT_W-1:0];
                  slot_start[pos] = store_top;
                  slot_size[pos]  = need[LENGTH_W-1:0];
                  slot_live[pos]  = 1'b1;
                  slot_next[pos]  = LINK_NONE;
                  slots_taken     = slots_taken + 1'b1;
                  store_top       = stop[STORE_W-1:0];
                  r.index  = pos;
                  r.offset = slot_start[pos][OFFSET_W-1:0];
                  r.length = need[LENGTH_W-1:0];
               end
            end
         end
         FN_FREE, FN_LOOKUP: begin
            r.index = idx;
            if (LINK_W'(idx) >= slots_taken) begin
               r.status = ST_RANGE;
            end else if (!slot_live[idx]) begin
               r.status = ST_DELETED;
            end else begin
               if (fn == FN_FREE) begin
                  slot_live[idx] = 1'b0;
                  slot_next[idx] = free_top;
                  free_top       = LINK_W'(idx);
               end
               r.offset = slot_start[idx][OFFSET_W-1:0];
               r.length = slot_size[idx];
            end
         end
         default: begin
         end
      endcase
      return r;
   endfunction

   function automatic int pick_gap(input bit rx_side);
      int calm;
      int r;
      int g;
      calm = rx_side ? calm_rx : calm_tx;
      r = $urandom_range(0, 99);
      if (calm > 0) begin
         calm--;
         g = 0;
      end else if (r < 4) begin
         calm = $urandom_range(15, 40);
         g = 0;
      end else if (r < 55) begin
         g = 0;
      end else if (r < 88) begin
         g = $urandom_range(1, 3);
      end else begin
         g = $urandom_range(4, 30);
      end
      if (rx_side) calm_rx = calm;
      else calm_tx = calm;
      return g;
   endfunction

   task automatic add_request(input logic [FUNC_W-1:0] fn, input logic [LENGTH_W-1:0] rec_len,
                              input logic [SLOT_W-1:0] idx);
      request_type it;
      it.func          = fn;
      it.record_length = rec_len;
      it.slot_index    = idx;
      pending_requests.insert(pending_requests.size(), it);
   endtask

   task automatic add_random(input int count, input int w_alloc, input int w_free,
                             input int w_look);
      int                  r;
      int                  hi;
      logic [FUNC_W-1:0]   fn;
      logic [LENGTH_W-1:0] rec_len;
      logic [SLOT_W-1:0]   idx;
      for (int k = 0; k < count; k++) begin
         case ($urandom_range(0, 9))
            0: rec_len = 12'd4095;
            1: rec_len = 12'd4094;
            2: rec_len = 12'd0;
            default: rec_len = LENGTH_W'($urandom_range(0, 4095));
         endcase
         hi = (allocs_issued > 255) ? 255 : allocs_issued;
         if ($urandom_range(0, 9) < 8) idx = SLOT_W'($urandom_range(0, hi));
         else idx = SLOT_W'($urandom_range(0, 255));
         r = $urandom_range(0, 99);
         if (r < w_alloc) begin
            fn = FN_ALLOC;
            if (rec_len != 12'd4095) allocs_issued++;
         end else if (r < w_alloc + w_free) begin
            fn = FN_FREE;
         end else if (r < w_alloc + w_free + w_look) begin
            fn = FN_LOOKUP;
         end else begin
            fn = FN_UNUSED;
         end
         add_request(fn, rec_len, idx);
      end
   endtask

   task automatic wait_drained();
      while (pending_requests.size() != 0 || req_valid || responses_due.size() != 0)
         @(negedge clock);
   endtask

   // request driver
   always @(posedge clock) begin
      request_type  nxt;
      response_type due;
      if (reset) begin
         req_valid <= 1'b0;
         tx_gap = 0;
      end else begin
         if (req_valid && !req_stall) begin
            due = slot_table_update(req_func, req_record_length, req_slot_index);
            responses_due.insert(responses_due.size(), due);
            tx_gap = pick_gap(1'b0);
         end
         if (!req_valid || !req_stall) begin
            if (tx_gap > 0) begin
               tx_gap--;
               req_valid <= 1'b0;
            end else if (pending_requests.size() > 0) begin
               nxt = pending_requests.pop_front();
               req_valid         <= 1'b1;
               req_func          <= nxt.func;
               req_record_length <= nxt.record_length;
               req_slot_index    <= nxt.slot_index;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // response stall, with a long hold when asked
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_asked != hold_done) begin
         hold_done = hold_asked;
         hold_left = 80;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (rx_gap > 0) begin
         rx_gap--;
         rsp_stall <= 1'b1;
      end else begin
         rx_gap = pick_gap(1'b1);
         rsp_stall <= 1'b0;
      end
   end

   // response monitor
   always @(posedge clock) begin
      response_type due;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (responses_due.size() == 0) begin
            $display("%0t: unexpected response, status %0d index %0d offset %0d",
                     $time, rsp_status, rsp_result_index, rsp_result_offset,
                     " length %0d reused %0d", rsp_result_length, rsp_reused);
            error_count++;
         end else begin
            due = responses_due.pop_front();
            if (rsp_status !== due.status || rsp_result_index !== due.index ||
                rsp_result_offset !== due.offset || rsp_result_length !== due.length ||
                rsp_reused !== due.reused) begin
               $display("%0t: mismatch, expected status %0d index %0d offset %0d",
                        $time, due.status, due.index, due.offset,
                        " length %0d reused %0d", due.length, due.reused);
               $display("%0t:           actual status %0d index %0d offset %0d",
                        $time, rsp_status, rsp_result_index, rsp_result_offset,
                        " length %0d reused %0d", rsp_result_length, rsp_reused);
               error_count++;
            end
         end
      end
   end

   initial begin
      reset <= 1'b1;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      add_request(FN_LOOKUP, 12'd0, 8'd0);
      add_request(FN_FREE, 12'd4095, 8'd255);
      add_request(FN_ALLOC, 12'd0, 8'd0);
      add_request(FN_ALLOC, 12'd4094, 8'd255);
      add_request(FN_ALLOC, 12'd4095, 8'd0);
      add_request(FN_ALLOC, 12'd100, 8'd0);
      add_request(FN_LOOKUP, 12'd0, 8'd1);
      add_request(FN_LOOKUP, 12'd4095, 8'd255);
      add_request(FN_FREE, 12'd0, 8'd0);
      add_request(FN_LOOKUP, 12'd0, 8'd0);
      add_request(FN_FREE, 12'd0, 8'd0);
      add_request(FN_ALLOC, 12'd2000, 8'd0);
      add_request(FN_FREE, 12'd0, 8'd2);
      add_request(FN_ALLOC, 12'd4095, 8'd0);
      add_request(FN_FREE, 12'd0, 8'd1);
      add_request(FN_ALLOC, 12'd4094, 8'd0);
      add_request(FN_ALLOC, 12'd4094, 8'd0);
      add_request(FN_ALLOC, 12'd4095, 8'd0);
      add_request(FN_UNUSED, 12'd4095, 8'd255);
      add_request(FN_UNUSED, 12'd0, 8'd0);
      add_request(FN_LOOKUP, 12'd0, 8'd2);
      allocs_issued = 3;

      add_random(300, 40, 25, 28);
      wait_drained();

      hold_asked++;
      add_random(300, 75, 5, 15);
      add_random(250, 35, 35, 25);
      wait_drained();
      repeat (20) @(negedge clock);

      if (responses_due.size() != 0) begin
         $display("%0t: %0d responses never arrived", $time, responses_due.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("record_slot_free_list_core_tb: done, clean");
      end else begin
         $display("record_slot_free_list_core_tb: done, errors");
      end
      $finish;
   end

   initial begin
      #(20 * 200000);
      $display("%0t: timeout", $time);
      $display("record_slot_free_list_core_tb: done, errors");
      $finish;
   end

endmodule

### sim.f
rtl/rsfl_pkg.sv
rtl/rsfl_ram.sv
rtl/rsfl_front.sv
rtl/rsfl_queue.sv
rtl/rsfl_back.sv
rtl/record_slot_free_list_core.sv
verif/record_slot_free_list_core_tb.sv
